// File: rtl/dcmq_pkg.sv
// shared constants, types and helpers for the matrix to quaternion converter
package dcmq_pkg;

   localparam int FIELD_W       = 18;
   localparam int FRAC_BITS_DEF = 16;
   // a sum of two matrix elements, and its magnitude
   localparam int NUM_W         = FIELD_W + 1;
   // quotient bits kept before clamping
   localparam int QUO_W         = FIELD_W;

   localparam logic [QUO_W-1:0]   QUO_LIM = QUO_W'(1) << (FIELD_W - 1);
   localparam logic [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W-1){1'b1}}};

   typedef logic signed [FIELD_W-1:0] field_type;

   // which part takes s/2
   typedef enum logic [1:0] {
      CASE_TRACE,
      CASE_X,
      CASE_Y,
      CASE_Z
   } case_type;

   typedef struct packed {
      case_type                 sel;
      logic                     invalid;
      logic [2:0]               neg;
      logic [2:0][NUM_W-1:0]    mag;
   } item_type;

   // signed width that holds the trace or the root argument
   function automatic int arg_width(input int frac);
      int w;
      w = (frac + 1 > FIELD_W + 2) ? frac + 1 : FIELD_W + 2;
      return w + 2;
   endfunction

endpackage

// File: rtl/dcmq_chan_if.sv
// request and response channel interfaces
interface dcmq_req_if import dcmq_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

interface dcmq_rsp_if import dcmq_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type quat_w, quat_x, quat_y, quat_z;
   logic      invalid;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, invalid,
                   input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, invalid,
                   output ready);
endinterface

// File: rtl/dcmq_front.sv
// front stage: takes a request, picks the branch, forms root argument and numerators
module dcmq_front import dcmq_pkg::*; #(
   parameter int  FRAC_BITS = FRAC_BITS_DEF,
   localparam int AS_W      = arg_width(FRAC_BITS),
   localparam int AU_W      = AS_W - 1
) (
   input  logic            clock,
   input  logic            reset,
   dcmq_req_if.sink        req_chan,
   output logic            out_valid,
   input  logic            out_ready,
   output item_type        out_item,
   output logic [AU_W-1:0] out_arg
);

   logic            valid_ff;
   item_type        item_ff, item_in;
   logic [AU_W-1:0] arg_ff, arg_in;

   logic signed [AS_W-1:0] d00, d11, d22, one_c, tr, arg;
   logic signed [NUM_W-1:0] n [3];
   logic signed [NUM_W-1:0] s01, s12, s20, t21, t02, t10;
   case_type sel;

   assign req_chan.ready = !valid_ff || out_ready;

   always_comb begin
      d00   = AS_W'(req_chan.m00);
      d11   = AS_W'(req_chan.m11);
      d22   = AS_W'(req_chan.m22);
      one_c = AS_W'(1) << FRAC_BITS;
      tr    = d00 + d11 + d22;

      // symmetric sums and antisymmetric differences
      s01 = NUM_W'(req_chan.m01) + NUM_W'(req_chan.m10);
      s12 = NUM_W'(req_chan.m12) + NUM_W'(req_chan.m21);
      s20 = NUM_W'(req_chan.m20) + NUM_W'(req_chan.m02);
      t21 = NUM_W'(req_chan.m21) - NUM_W'(req_chan.m12);
      t02 = NUM_W'(req_chan.m02) - NUM_W'(req_chan.m20);
      t10 = NUM_W'(req_chan.m10) - NUM_W'(req_chan.m01);

      if (tr > 0) begin
         sel = CASE_TRACE;
      end else if (req_chan.m22 > req_chan.m00 && req_chan.m22 > req_chan.m11) begin
         sel = CASE_Z;
      end else if (req_chan.m11 > req_chan.m00) begin
         sel = CASE_Y;
      end else begin
         sel = CASE_X;
      end

      unique case (sel)
         CASE_TRACE: begin
            arg  = tr + one_c;
            n[0] = t21; n[1] = t02; n[2] = t10;
         end
         CASE_X: begin
            arg  = d00 - d11 - d22 + one_c;
            n[0] = s01; n[1] = s20; n[2] = t21;
         end
         CASE_Y: begin
            arg  = d11 - d22 - d00 + one_c;
            n[0] = s12; n[1] = s01; n[2] = t02;
         end
         CASE_Z: begin
            arg  = d22 - d00 - d11 + one_c;
            n[0] = s20; n[1] = s12; n[2] = t10;
         end
         default: begin
            arg  = '0;
            n[0] = '0; n[1] = '0; n[2] = '0;
         end
      endcase

      item_in.sel     = sel;
      item_in.invalid = (arg <= 0);
      for (int l = 0; l < 3; l++) begin
         item_in.neg[l] = n[l][NUM_W-1];
         item_in.mag[l] = n[l][NUM_W-1] ? NUM_W'(-n[l]) : NUM_W'(n[l]);
      end
      arg_in = item_in.invalid ? '0 : arg[AU_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         item_ff <= item_in;
         arg_ff  <= arg_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_arg   = arg_ff;

endmodule

// File: rtl/dcmq_queue.sv
// two-entry queue between the front stage and the arithmetic pipeline
module dcmq_queue import dcmq_pkg::*; #(
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   logic [DATA_W-1:0] mem_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   assign pop       = out_ready && (count_ff != 2'd0);
   assign in_ready  = (count_ff != 2'd2) || pop;
   assign push      = in_valid && in_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// File: rtl/dcmq_back.sv
// arithmetic pipeline: square root, three dividers, clamping and output register
module dcmq_back import dcmq_pkg::*; #(
   parameter int  FRAC_BITS = FRAC_BITS_DEF,
   localparam int AU_W      = arg_width(FRAC_BITS) - 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  item_type        in_item,
   input  logic [AU_W-1:0] in_arg,
   dcmq_rsp_if.source      rsp_chan
);

   localparam int RAD_W = ((AU_W + FRAC_BITS + 1) / 2) * 2;
   localparam int SQ_W  = RAD_W / 2;
   localparam int R_W   = SQ_W + 2;
   localparam int D_W   = NUM_W + FRAC_BITS;
   localparam int DV_W  = SQ_W + 1 + QUO_W;
   localparam int CW    = (D_W > DV_W) ? D_W : DV_W;

   logic en;
   assign en       = !rsp_chan.valid || rsp_chan.ready;
   assign in_ready = en;

   // square root, one result bit per stage
   logic             sv_ff    [SQ_W];
   item_type         si_ff    [SQ_W];
   logic [R_W-1:0]   srem_ff  [SQ_W];
   logic [SQ_W-1:0]  sroot_ff [SQ_W];
   logic [RAD_W-1:0] srad_ff  [SQ_W];

   for (genvar g = 0; g < SQ_W; g++) begin : g_sqrt
      localparam int PREV = (g == 0) ? 0 : g - 1;
      logic             v_i;
      item_type         it_i;
      logic [R_W-1:0]   rem_i, rem_sh, trial, rem_n;
      logic [SQ_W-1:0]  root_i, root_n;
      logic [RAD_W-1:0] rad_i;
      logic             ge;

      always_comb begin
         if (g == 0) begin
            v_i    = in_valid;
            it_i   = in_item;
            rem_i  = '0;
            root_i = '0;
            rad_i  = RAD_W'({in_arg, {FRAC_BITS{1'b0}}});
         end else begin
            v_i    = sv_ff[PREV];
            it_i   = si_ff[PREV];
            rem_i  = srem_ff[PREV];
            root_i = sroot_ff[PREV];
            rad_i  = srad_ff[PREV];
         end
         rem_sh = {rem_i[R_W-3:0], rad_i[RAD_W-1 -: 2]};
         trial  = {root_i, 2'b01};
         ge     = (rem_sh >= trial);
         rem_n  = ge ? rem_sh - trial : rem_sh;
         root_n = {root_i[SQ_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[g] <= 1'b0;
         end else if (en) begin
            sv_ff[g] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            si_ff[g]    <= it_i;
            srem_ff[g]  <= rem_n;
            sroot_ff[g] <= root_n;
            srad_ff[g]  <= rad_i << 2;
         end
      end
   end

   // divider setup: divisor 2s, overflow check, upper dividend bits
   logic                    pv_ff;
   item_type                pi_ff;
   logic [SQ_W:0]           pd_ff, pd_in;
   logic [2:0]              povf_ff, povf_in;
   logic [2:0][R_W-1:0]     prem_ff, prem_in;
   logic [2:0][QUO_W-1:0]   plow_ff, plow_in;
   logic [FIELD_W-1:0]      phalf_ff, phalf_in;

   always_comb begin
      logic [SQ_W-1:0] s, half;
      logic [D_W-1:0]  dd;
      s     = sroot_ff[SQ_W-1];
      half  = s >> 1;
      pd_in = {s, 1'b0};
      phalf_in = (64'(half) > 64'(SAT_MAX)) ? SAT_MAX : FIELD_W'(half);
      for (int l = 0; l < 3; l++) begin
         dd         = {si_ff[SQ_W-1].mag[l], {FRAC_BITS{1'b0}}};
         povf_in[l] = (CW'(dd) >= CW'({pd_in, {QUO_W{1'b0}}}));
         prem_in[l] = R_W'(dd[D_W-1:QUO_W]);
         plow_in[l] = dd[QUO_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= sv_ff[SQ_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pi_ff    <= si_ff[SQ_W-1];
         pd_ff    <= pd_in;
         povf_ff  <= povf_in;
         prem_ff  <= prem_in;
         plow_ff  <= plow_in;
         phalf_ff <= phalf_in;
      end
   end

   // three restoring dividers in lockstep, one quotient bit per stage
   logic                  dv_ff   [QUO_W];
   item_type              di_ff   [QUO_W];
   logic [SQ_W:0]         dd_ff   [QUO_W];
   logic [2:0]            dovf_ff [QUO_W];
   logic [2:0][R_W-1:0]   drem_ff [QUO_W];
   logic [2:0][QUO_W-1:0] dlow_ff [QUO_W];
   logic [2:0][QUO_W-1:0] dq_ff   [QUO_W];
   logic [FIELD_W-1:0]    dhalf_ff[QUO_W];

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      localparam int PREV = (g == 0) ? 0 : g - 1;
      logic                  v_i;
      item_type              it_i;
      logic [SQ_W:0]         d_i;
      logic [2:0]            ovf_i;
      logic [2:0][R_W-1:0]   rem_i, rem_n;
      logic [2:0][QUO_W-1:0] low_i, low_n, q_i, q_n;
      logic [FIELD_W-1:0]    half_i;

      always_comb begin
         logic [R_W-1:0] rsh;
         logic           ge;
         if (g == 0) begin
            v_i    = pv_ff;
            it_i   = pi_ff;
            d_i    = pd_ff;
            ovf_i  = povf_ff;
            rem_i  = prem_ff;
            low_i  = plow_ff;
            q_i    = '0;
            half_i = phalf_ff;
         end else begin
            v_i    = dv_ff[PREV];
            it_i   = di_ff[PREV];
            d_i    = dd_ff[PREV];
            ovf_i  = dovf_ff[PREV];
            rem_i  = drem_ff[PREV];
            low_i  = dlow_ff[PREV];
            q_i    = dq_ff[PREV];
            half_i = dhalf_ff[PREV];
         end
         for (int l = 0; l < 3; l++) begin
            rsh      = {rem_i[l][R_W-2:0], low_i[l][QUO_W-1]};
            ge       = (rsh >= R_W'(d_i));
            rem_n[l] = ge ? rsh - R_W'(d_i) : rsh;
            q_n[l]   = {q_i[l][QUO_W-2:0], ge};
            low_n[l] = low_i[l] << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g] <= 1'b0;
         end else if (en) begin
            dv_ff[g] <= v_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            di_ff[g]    <= it_i;
            dd_ff[g]    <= d_i;
            dovf_ff[g]  <= ovf_i;
            drem_ff[g]  <= rem_n;
            dlow_ff[g]  <= low_n;
            dq_ff[g]    <= q_n;
            dhalf_ff[g] <= half_i;
         end
      end
   end

   // clamp, sign, route parts to their outputs
   logic               ov_ff, ov_in;
   logic [FIELD_W-1:0] w_ff, x_ff, y_ff, z_ff, w_in, x_in, y_in, z_in;
   logic               inv_ff, inv_in;

   always_comb begin
      item_type           it;
      logic [QUO_W-1:0]   qc;
      logic [FIELD_W-1:0] r [3];
      logic [FIELD_W-1:0] h;
      it = di_ff[QUO_W-1];
      h  = dhalf_ff[QUO_W-1];
      for (int l = 0; l < 3; l++) begin
         qc = (dovf_ff[QUO_W-1][l] || dq_ff[QUO_W-1][l] > QUO_LIM) ?
              QUO_LIM : dq_ff[QUO_W-1][l];
         if (it.neg[l]) begin
            r[l] = FIELD_W'(-qc);
         end else begin
            r[l] = (qc == QUO_LIM) ? SAT_MAX : FIELD_W'(qc);
         end
      end
      unique case (it.sel)
         CASE_TRACE: begin w_in = h;    x_in = r[0]; y_in = r[1]; z_in = r[2]; end
         CASE_X:     begin w_in = r[2]; x_in = h;    y_in = r[0]; z_in = r[1]; end
         CASE_Y:     begin w_in = r[2]; x_in = r[1]; y_in = h;    z_in = r[0]; end
         CASE_Z:     begin w_in = r[2]; x_in = r[0]; y_in = r[1]; z_in = h;    end
         default:    begin w_in = '0;   x_in = '0;   y_in = '0;   z_in = '0;   end
      endcase
      inv_in = it.invalid;
      if (it.invalid) begin
         w_in = '0; x_in = '0; y_in = '0; z_in = '0;
      end
      ov_in = dv_ff[QUO_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff   <= w_in;
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         inv_ff <= inv_in;
      end
   end

   assign rsp_chan.valid   = ov_ff;
   assign rsp_chan.quat_w  = w_ff;
   assign rsp_chan.quat_x  = x_ff;
   assign rsp_chan.quat_y  = y_ff;
   assign rsp_chan.quat_z  = z_ff;
   assign rsp_chan.invalid = inv_ff;

endmodule

// File: rtl/dcm_to_quaternion_top.sv
// Rotation matrix to unit quaternion converter (Shepperd's method), fixed point.
// Takes one request per clock while the receiver keeps up, and returns one
// response per request, in order. SQ_W is the number of square-root stages,
// (arg width + FRAC_BITS + 1) / 2; with FRAC_BITS = 16 that is 19 stages.
// The pipeline depth is set by the bit-per-stage square root followed by
// three bit-per-stage dividers that run side by side. A two-entry queue
// between the front stage and the arithmetic pipeline lets either side
// stall on its own.
module dcm_to_quaternion_top import dcmq_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   dcmq_req_if.sink   req_chan,
   dcmq_rsp_if.source rsp_chan
);

   localparam int AU_W   = arg_width(FRAC_BITS) - 1;
   localparam int DATA_W = $bits(item_type) + AU_W;

   logic              fr_valid, fr_ready;
   item_type          fr_item;
   logic [AU_W-1:0]   fr_arg;
   logic              bk_valid, bk_ready;
   logic [DATA_W-1:0] bk_data;

   dcmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item),
      .out_arg   (fr_arg)
   );

   dcmq_queue #(.DATA_W(DATA_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   ({fr_arg, fr_item}),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  (bk_data)
   );

   dcmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (bk_valid),
      .in_ready (bk_ready),
      .in_item  (item_type'(bk_data[$bits(item_type)-1:0])),
      .in_arg   (bk_data[DATA_W-1 -: AU_W]),
      .rsp_chan (rsp_chan)
   );

endmodule

// File: tb/dcm_to_quaternion_top_tb.sv
// testbench for the matrix to quaternion converter: directed table, then random matrices
`timescale 1ns / 1ps

module dcm_to_quaternion_top_tb;
   import dcmq_pkg::*;

   localparam int FRAC      = 16;
   localparam int WDOG_MAX  = 20000;
   localparam int DRAIN_CYC = 60;
   localparam int N_RANDOM  = 1700;
   localparam longint ONE_Q = 64'sd1 << FRAC;

   typedef struct {
      field_type m [9];
   } matrix_type;

   typedef struct {
      field_type w, x, y, z;
      logic      inv;
   } quat_type;

   typedef struct {
      matrix_type mat;
      logic       known;
      quat_type   q;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dcmq_req_if req_chan ();
   dcmq_rsp_if rsp_chan ();

   dcm_to_quaternion_top #(.FRAC_BITS(FRAC)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #1 clock = ~clock;

   quat_type  quat_q [$];
   quat_type  known_q [$];
   logic      known_flag_q [$];
   int        errors     = 0;
   int        n_sent     = 0;
   int        n_checked  = 0;
   int        idle_pct   = 0;
   int        stall_pct  = 0;
   int        hold_cnt   = 0;
   bit        hold_start = 1'b0;
   int        quiet_cyc  = 0;
   int        n_trace    = 0;
   int        n_diag     = 0;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint clamp18(input longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
   endfunction

   function automatic longint scaled_div(input longint num, input longint unsigned s);
      logic neg;
      longint unsigned mag, quo;
      neg = num < 0;
      mag = neg ? longint'(-num) : num;
      quo = (mag << FRAC) / (2 * s);
      if (quo > 131072) quo = 131072;
      return clamp18(neg ? -longint'(quo) : longint'(quo));
   endfunction

   function automatic quat_type shepperd(input matrix_type mt);
      longint m [3][3];
      longint q [4];
      longint tr, arg;
      longint unsigned s;
      int i, j, k;
      quat_type r;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            m[a][b] = mt.m[a*3+b];
      for (int a = 0; a < 4; a++) q[a] = 0;
      r.inv = 1'b0;
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         s    = int_sqrt(longint'(tr + ONE_Q) << FRAC);
         q[0] = clamp18(s >> 1);
         q[1] = scaled_div(m[2][1] - m[1][2], s);
         q[2] = scaled_div(m[0][2] - m[2][0], s);
         q[3] = scaled_div(m[1][0] - m[0][1], s);
      end else begin
         i = 0;
         if (m[1][1] > m[i][i]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         arg = m[i][i] - m[j][j] - m[k][k] + ONE_Q;
         if (arg <= 0) begin
            r.inv = 1'b1;
         end else begin
            s      = int_sqrt(longint'(arg) << FRAC);
            q[i+1] = clamp18(s >> 1);
            q[j+1] = scaled_div(m[i][j] + m[j][i], s);
            q[k+1] = scaled_div(m[k][i] + m[i][k], s);
            q[0]   = scaled_div(m[k][j] - m[j][k], s);
         end
      end
      r.w = q[0][17:0];
      r.x = q[1][17:0];
      r.y = q[2][17:0];
      r.z = q[3][17:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH result %0d %s: got %0d expected %0d", n_checked, what, got, want);
      errors++;
   endtask

   // receiver side: random stall, or a long hold-off once asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready = 1'b0;
      end else if (hold_start) begin
         hold_start     = 1'b0;
         hold_cnt       = 400;
         rsp_chan.ready = 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(99) >= stall_pct);
      end
   end

   // checking and prediction at the rising edge
   always @(posedge clock) begin
      quat_type want;
      logic     acc;
      acc = 1'b0;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         acc = 1'b1;
         if (quat_q.size() == 0) begin
            report_mismatch("unexpected quat_w", rsp_chan.quat_w, 0);
         end else begin
            want = quat_q.pop_front();
            if (rsp_chan.quat_w !== want.w) report_mismatch("quat_w", rsp_chan.quat_w, want.w);
            if (rsp_chan.quat_x !== want.x) report_mismatch("quat_x", rsp_chan.quat_x, want.x);
            if (rsp_chan.quat_y !== want.y) report_mismatch("quat_y", rsp_chan.quat_y, want.y);
            if (rsp_chan.quat_z !== want.z) report_mismatch("quat_z", rsp_chan.quat_z, want.z);
            if (rsp_chan.invalid !== want.inv)
               report_mismatch("invalid", rsp_chan.invalid, want.inv);
            n_checked++;
         end
      end
      if (!reset && req_chan.valid && req_chan.ready) begin
         matrix_type mt;
         acc = 1'b1;
         mt.m = '{req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
                  req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22};
         want = shepperd(mt);
         if (known_flag_q.pop_front()) want = known_q.pop_front();
         quat_q.push_back(want);
         if (req_chan.m00 + req_chan.m11 + req_chan.m22 > 0) n_trace++;
         else n_diag++;
         n_sent++;
      end
      if (reset || acc) quiet_cyc = 0;
      else quiet_cyc++;
      if (quiet_cyc >= WDOG_MAX) begin
         $display("watchdog: no handshake in %0d cycles", WDOG_MAX);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_matrix(input matrix_type mt, input logic known, input quat_type q);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      known_flag_q.push_back(known);
      if (known) known_q.push_back(q);
      req_chan.valid = 1'b1;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
       req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} =
         {mt.m[0], mt.m[1], mt.m[2], mt.m[3], mt.m[4], mt.m[5], mt.m[6], mt.m[7], mt.m[8]};
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   function automatic field_type rand_elem();
      case ($urandom_range(5))
         0: return field_type'($urandom);
         1: return $urandom_range(1) ? 18'sd131071 : -18'sd131072;
         2: return field_type'(int'($urandom_range(131072)) - 65536);
         3: return field_type'(int'($urandom_range(2048)) - 1024);
         default: return field_type'(int'($urandom_range(262143)) - 131072);
      endcase
   endfunction

   // mostly rotation-like: one dominant diagonal or a positive trace
   function automatic matrix_type rand_matrix();
      matrix_type mt;
      int dom;
      for (int a = 0; a < 9; a++) mt.m[a] = rand_elem();
      if ($urandom_range(3) != 0) begin
         dom = $urandom_range(3);
         for (int a = 0; a < 3; a++)
            mt.m[a*4] = field_type'(-int'($urandom_range(65536)));
         if (dom < 3) mt.m[dom*4] = field_type'($urandom_range(65536));
         else for (int a = 0; a < 3; a++) mt.m[a*4] = field_type'($urandom_range(65536));
      end
      return mt;
   endfunction

   function automatic matrix_type diag_mat(input int a, input int b, input int c);
      matrix_type mt;
      for (int n = 0; n < 9; n++) mt.m[n] = '0;
      mt.m[0] = field_type'(a); mt.m[4] = field_type'(b); mt.m[8] = field_type'(c);
      return mt;
   endfunction

   function automatic quat_type quat_of(input int w, input int x, input int y, input int z);
      quat_type q;
      q.w = field_type'(w); q.x = field_type'(x);
      q.y = field_type'(y); q.z = field_type'(z);
      q.inv = 1'b0;
      return q;
   endfunction

   initial begin
      row_type    rows [$];
      row_type    rw;
      matrix_type mt;
      quat_type   none;
      int         phase_pct [4][2];

      req_chan.valid = 1'b0;
      {req_chan.m00, req_chan.m01, req_chan.m02, req_chan.m10, req_chan.m11,
       req_chan.m12, req_chan.m20, req_chan.m21, req_chan.m22} = '0;
      rsp_chan.ready = 1'b0;
      none = quat_of(0, 0, 0, 0);
      phase_pct = '{'{0, 0}, '{57, 0}, '{0, 57}, '{30, 30}};

      // identity and zero matrix are read off directly
      rw.known = 1'b1;
      rw.mat = diag_mat(65536, 65536, 65536);    rw.q = quat_of(65536, 0, 0, 0); rows.push_back(rw);
      rw.mat = diag_mat(0, 0, 0);                rw.q = quat_of(0, 32768, 0, 0); rows.push_back(rw);
      rw.known = 1'b0; rw.q = none;
      // half turns about each axis, and diagonal ties
      rw.mat = diag_mat(65536, -65536, -65536);  rows.push_back(rw);
      rw.mat = diag_mat(-65536, 65536, -65536);  rows.push_back(rw);
      rw.mat = diag_mat(-65536, -65536, 65536);  rows.push_back(rw);
      rw.mat = diag_mat(-100, -100, -100);       rows.push_back(rw);
      rw.mat = diag_mat(-200, -100, -100);       rows.push_back(rw);
      rw.mat = diag_mat(-131072, -131072, -131072); rows.push_back(rw);
      rw.mat = diag_mat(131071, 131071, 131071); rows.push_back(rw);
      rw.mat = diag_mat(1, 0, 0);                rows.push_back(rw);
      // saturating off-diagonals with alternating signs
      for (int n = 0; n < 4; n++) begin
         mt = diag_mat(-131072, -131072, -131072);
         for (int a = 0; a < 9; a++)
            if (a % 4 != 0) mt.m[a] = ((a + n) % 2) ? 18'sd131071 : -18'sd131072;
         if (n == 3) mt = diag_mat(131071, -131072, -131072);
         rw.mat = mt; rows.push_back(rw);
      end
      for (int n = 0; n < 4; n++) begin
         mt = diag_mat(1, 1, 1);
         for (int a = 0; a < 9; a++)
            if (a % 4 != 0) mt.m[a] = (n[0] ^ a[0]) ? 18'sd131071 : -18'sd131072;
         rw.mat = mt; rows.push_back(rw);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[r]) send_matrix(rows[r].mat, rows[r].known, rows[r].q);
      req_chan.valid = 1'b0;
      // let everything drain before the random part
      while (quat_q.size() != 0) @(negedge clock);

      for (int p = 0; p < 4; p++) begin
         idle_pct  = phase_pct[p][0];
         stall_pct = phase_pct[p][1];
         if (p == 1) hold_start = 1'b1;
         for (int n = 0; n < N_RANDOM / 4; n++) send_matrix(rand_matrix(), 1'b0, none);
         req_chan.valid = 1'b0;
         while (quat_q.size() != 0) @(negedge clock);
      end

      idle_pct = 0; stall_pct = 0;
      repeat (DRAIN_CYC) @(negedge clock);
      $display("sent %0d matrices (%0d positive trace, %0d diagonal branch), %0d results checked",
               n_sent, n_trace, n_diag, n_checked);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
